>>> sv/fokker_planck_stencil_sweep_macros.svh
// Assertion macros for the stencil sweep checker.
`ifndef FOKKER_PLANCK_STENCIL_SWEEP_MACROS_SVH
`define FOKKER_PLANCK_STENCIL_SWEEP_MACROS_SVH
// clocked assertion, off while reset is high
`define FPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// condition that must never be seen
`define FPS_NEVER(lbl, cond, msg) `FPS_ASSERT(lbl, !(cond), msg)
`endif

>>> sv/fps_pkg.sv
// Types, constants and helper functions shared by the stencil sweep modules.
package fps_pkg;

   localparam int MAX_POINTS = 512;
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_POINTS - 1);
   localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_TWO = IDX_W'(2);

   localparam logic [41:0] SUM_MAX = '1;
   localparam logic [39:0] OUT_MAX = '1;

   localparam logic [31:0] DRIFT_GAIN_RST = 32'd135818;
   localparam logic [31:0] DIFFUSION_GAIN_RST = 32'd27163779;
   localparam logic signed [31:0] GRID_ORIGIN_RST = -32'sd536870912;
   localparam logic [30:0] GRID_STEP_RST = 31'd2684355;
   localparam logic signed [31:0] TILT_RST = 32'sd5033165;

   typedef enum logic [2:0] {
      CSR_DRIFT_GAIN,
      CSR_DIFFUSION_GAIN,
      CSR_GRID_ORIGIN,
      CSR_GRID_STEP,
      CSR_TILT
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FORCE,
      ST_LANE,
      ST_LOAD,
      ST_SEND
   } state_type;

   typedef enum logic [2:0] {
      JOB_PASS_W0,
      JOB_PASS_A,
      JOB_FIRST,
      JOB_INNER,
      JOB_EDGE
   } job_type;

   typedef enum logic [1:0] {
      FT_GC,
      FT_G0,
      FT_GM,
      FT_DONE
   } force_tag_type;

   typedef enum logic [3:0] {
      LS_IDLE,
      LS_MUL_P1,
      LS_MUL_P2,
      LS_MUL_P3,
      LS_FORM,
      LS_DRIFT_LO,
      LS_DRIFT_HI,
      LS_DIFF_LO,
      LS_DIFF_HI,
      LS_SUM
   } lane_step_type;

   typedef struct packed {
      logic signed [31:0] sample_a;
      logic signed [31:0] sample_b;
      logic               first_point;
      logic               last_point_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_a;
      logic signed [31:0] new_b;
      logic [8:0]         point_index;
      logic               end_of_sweep;
      logic [39:0]        distance;
      logic [39:0]        mass_a;
      logic [39:0]        mass_b;
   } rsp_type;

   typedef struct packed {
      logic             issue;
      force_tag_type    tag;
      logic [IDX_W-1:0] idx;
   } force_req_type;

   typedef struct packed {
      logic               valid;
      force_tag_type      tag;
      logic signed [31:0] g;
   } force_rsp_type;

   typedef struct packed {
      logic    start;
      job_type mode;
   } lane_ctrl_type;

   typedef struct packed {
      logic acc;
      logic restart;
      logic finish;
   } mass_ctrl_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [41:0] sat_add(input logic [41:0] s, input logic [32:0] v);
      logic [42:0] t;
      t = {1'b0, s} + {10'b0, v};
      return t[42] ? SUM_MAX : t[41:0];
   endfunction

endpackage

>>> sv/fps_force.sv
// Four-stage force pipeline: position, square, cubic term, tilt and saturation.
module fps_force (
   input  logic                    clock,
   input  logic                    reset,
   input  fps_pkg::force_req_type  req,
   input  logic signed [31:0]      origin,
   input  logic [30:0]             step,
   input  logic signed [31:0]      tilt,
   output fps_pkg::force_rsp_type  rsp
);

   localparam int OW = fps_pkg::IDX_W + 31;

   logic [OW-1:0]           ofs;
   logic signed [OW+1:0]    xsum;
   logic signed [63:0]      xx;
   logic signed [31:0]      dm;
   logic signed [63:0]      cube;

   logic signed [31:0]      x1_ff, x2_ff;
   logic [30:0]             d2_ff;
   logic signed [35:0]      t3_ff;
   logic signed [31:0]      g4_ff;
   logic [3:0]              v_ff;
   fps_pkg::force_tag_type  tag1_ff, tag2_ff, tag3_ff, tag4_ff;

   always_comb begin
      ofs  = OW'(req.idx) * OW'(step);
      xsum = $signed({2'b00, ofs}) + (OW+2)'(origin);
      xx   = 64'(x1_ff) * 64'(x1_ff);
      dm   = $signed({1'b0, d2_ff}) - 32'sd16777216;
      cube = 64'(dm) * 64'(x2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], req.issue};
      end
      x1_ff   <= fps_pkg::sat32(64'(xsum));
      tag1_ff <= req.tag;
      x2_ff   <= x1_ff;
      d2_ff   <= xx[62:32];
      tag2_ff <= tag1_ff;
      t3_ff   <= $signed(cube[63:28]);
      tag3_ff <= tag2_ff;
      g4_ff   <= fps_pkg::sat32((64'(t3_ff) <<< 2) - 64'(tilt));
      tag4_ff <= tag3_ff;
   end

   assign rsp.valid = v_ff[3];
   assign rsp.tag   = tag4_ff;
   assign rsp.g     = g4_ff;

endmodule

>>> sv/fps_lane.sv
// One lane: forms drift and diffusion terms with a single shared multiplier.
module fps_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  fps_pkg::lane_ctrl_type ctrl,
   input  logic signed [31:0]     p_cur,
   input  logic signed [31:0]     p_prev,
   input  logic signed [31:0]     p_old,
   input  logic signed [31:0]     gc,
   input  logic signed [31:0]     g0,
   input  logic signed [31:0]     gm,
   input  logic [31:0]            drift,
   input  logic [31:0]            diff,
   output logic                   done,
   output logic signed [31:0]     result
);

   fps_pkg::lane_step_type st_ff, st_in;

   logic signed [32:0] op_a, op_b;
   logic signed [65:0] prod_ff;
   logic signed [39:0] p1_ff, p2_ff, p3;
   logic signed [41:0] f_ff, l_ff, f_in, l_in;
   logic signed [31:0] base_ff, base_in;
   logic [31:0]        hi32_ff;
   logic signed [47:0] dterm_ff;
   logic signed [63:0] total;
   logic signed [31:0] res_ff;
   logic               done_ff;

   always_comb begin
      case (st_ff)
         fps_pkg::LS_IDLE:     st_in = ctrl.start ? fps_pkg::LS_MUL_P1 : fps_pkg::LS_IDLE;
         fps_pkg::LS_MUL_P1:   st_in = fps_pkg::LS_MUL_P2;
         fps_pkg::LS_MUL_P2:   st_in = fps_pkg::LS_MUL_P3;
         fps_pkg::LS_MUL_P3:   st_in = fps_pkg::LS_FORM;
         fps_pkg::LS_FORM:     st_in = fps_pkg::LS_DRIFT_LO;
         fps_pkg::LS_DRIFT_LO: st_in = fps_pkg::LS_DRIFT_HI;
         fps_pkg::LS_DRIFT_HI: st_in = fps_pkg::LS_DIFF_LO;
         fps_pkg::LS_DIFF_LO:  st_in = fps_pkg::LS_DIFF_HI;
         fps_pkg::LS_DIFF_HI:  st_in = fps_pkg::LS_SUM;
         default:              st_in = fps_pkg::LS_IDLE;
      endcase
   end

   always_comb begin
      case (st_ff)
         fps_pkg::LS_MUL_P1: begin
            op_a = 33'(p_cur);
            op_b = 33'(gc);
         end
         fps_pkg::LS_MUL_P2: begin
            op_a = 33'(p_old);
            op_b = 33'(gm);
         end
         fps_pkg::LS_MUL_P3: begin
            op_a = 33'(p_prev);
            op_b = 33'(g0);
         end
         fps_pkg::LS_DRIFT_LO: begin
            op_a = $signed({1'b0, f_ff[31:0]});
            op_b = $signed({1'b0, drift});
         end
         fps_pkg::LS_DRIFT_HI: begin
            op_a = 33'($signed(f_ff[41:32]));
            op_b = $signed({1'b0, drift});
         end
         fps_pkg::LS_DIFF_LO: begin
            op_a = $signed({1'b0, l_ff[31:0]});
            op_b = $signed({1'b0, diff});
         end
         fps_pkg::LS_DIFF_HI: begin
            op_a = 33'($signed(l_ff[41:32]));
            op_b = $signed({1'b0, diff});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      p3 = $signed(prod_ff[63:24]);
      case (ctrl.mode)
         fps_pkg::JOB_FIRST: begin
            f_in    = 42'(p1_ff) + 42'(p3);
            l_in    = 42'(p_cur) - 42'(p_prev);
            base_in = p_prev;
         end
         fps_pkg::JOB_INNER: begin
            f_in    = 42'(p1_ff) - 42'(p2_ff);
            l_in    = 42'(p_old) + 42'(p_cur) - (42'(p_prev) <<< 1);
            base_in = p_prev;
         end
         fps_pkg::JOB_EDGE: begin
            f_in    = -42'(p1_ff) - 42'(p3);
            l_in    = 42'(p_prev) - 42'(p_cur);
            base_in = p_cur;
         end
         default: begin
            f_in    = '0;
            l_in    = '0;
            base_in = p_cur;
         end
      endcase
      total = 64'(base_ff) + 64'(dterm_ff) + 64'($signed(prod_ff[47:0]))
            + 64'($signed({1'b0, hi32_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= fps_pkg::LS_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= (st_ff == fps_pkg::LS_SUM);
      end
      prod_ff <= 66'(op_a) * 66'(op_b);
      case (st_ff)
         fps_pkg::LS_MUL_P2:   p1_ff <= $signed(prod_ff[63:24]);
         fps_pkg::LS_MUL_P3:   p2_ff <= $signed(prod_ff[63:24]);
         fps_pkg::LS_FORM: begin
            f_ff    <= f_in;
            l_ff    <= l_in;
            base_ff <= base_in;
         end
         fps_pkg::LS_DRIFT_HI: hi32_ff <= prod_ff[63:32];
         fps_pkg::LS_DIFF_LO: begin
            dterm_ff <= $signed(prod_ff[47:0]) + $signed({16'b0, hi32_ff});
         end
         fps_pkg::LS_DIFF_HI:  hi32_ff <= prod_ff[63:32];
         fps_pkg::LS_SUM:      res_ff <= fps_pkg::sat32(total);
         default:              ;
      endcase
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

>>> sv/fps_mass.sv
// Running L1 distance and mass sums, scaled by the grid step at the end of a sweep.
module fps_mass (
   input  logic                   clock,
   input  logic                   reset,
   input  fps_pkg::mass_ctrl_type ctrl,
   input  logic signed [31:0]     a,
   input  logic signed [31:0]     b,
   input  logic [30:0]            step,
   output logic [39:0]            l1_dist,
   output logic [39:0]            mass_a,
   output logic [39:0]            mass_b,
   output logic                   done
);

   logic [41:0]        dsum_ff, asum_ff, bsum_ff;
   logic [41:0]        dbase, abase, bbase;
   logic signed [32:0] da;
   logic [32:0]        ad, aa, ab;
   logic [2:0]         sc_ff;
   logic [20:0]        op;
   logic [51:0]        prod_ff, hi_ff;
   logic [72:0]        tot;
   logic [39:0]        scaled;
   logic [39:0]        dist_ff, ma_ff, mb_ff;
   logic               done_ff;

   always_comb begin
      da    = 33'(a) - 33'(b);
      ad    = da[32] ? 33'(-da) : 33'(da);
      aa    = a[31] ? 33'(-33'(a)) : 33'(a);
      ab    = b[31] ? 33'(-33'(b)) : 33'(b);
      dbase = ctrl.restart ? '0 : dsum_ff;
      abase = ctrl.restart ? '0 : asum_ff;
      bbase = ctrl.restart ? '0 : bsum_ff;
      case (sc_ff)
         3'd1:    op = dsum_ff[41:21];
         3'd2:    op = dsum_ff[20:0];
         3'd3:    op = asum_ff[41:21];
         3'd4:    op = asum_ff[20:0];
         3'd5:    op = bsum_ff[41:21];
         3'd6:    op = bsum_ff[20:0];
         default: op = '0;
      endcase
      tot    = {hi_ff, 21'b0} + 73'(prod_ff);
      scaled = (|tot[72:68]) ? fps_pkg::OUT_MAX : tot[67:28];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dsum_ff <= '0;
         asum_ff <= '0;
         bsum_ff <= '0;
         sc_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         if (ctrl.acc) begin
            dsum_ff <= fps_pkg::sat_add(dbase, ad);
            asum_ff <= fps_pkg::sat_add(abase, aa);
            bsum_ff <= fps_pkg::sat_add(bbase, ab);
            done_ff <= 1'b0;
            sc_ff   <= ctrl.finish ? 3'd1 : 3'd0;
         end else if (sc_ff != 3'd0) begin
            sc_ff   <= sc_ff + 3'd1;
            if (sc_ff == 3'd7) begin
               done_ff <= 1'b1;
            end
         end
      end
      prod_ff <= 52'(op) * 52'(step);
      if (!sc_ff[0]) begin
         hi_ff <= prod_ff;
      end
      case (sc_ff)
         3'd3:    dist_ff <= scaled;
         3'd5:    ma_ff   <= scaled;
         3'd7:    mb_ff   <= scaled;
         default: ;
      endcase
   end

   assign l1_dist = dist_ff;
   assign mass_a  = ma_ff;
   assign mass_b  = mb_ff;
   assign done    = done_ff;

endmodule

>>> sv/fokker_planck_stencil_sweep.sv
// Top level of the streaming Fokker-Planck stencil sweep.
// One item at a time: an accepted sample is held while its results are formed, and
// req_ready is low until the last of them has been taken. An interior point passes
// through three forces in the 4-stage force pipeline, then the nine-step multiply
// sequence each lane runs on its one multiplier, then the output register; the closing
// point of a sweep adds an edge update through the lanes. A first item that is not
// also the last gives no result; sweeps of one or two points need no force, and
// their final result waits for the step-scaling of the three sums. No clearing pass
// after reset.
module fokker_planck_stencil_sweep (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fps_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   localparam int IW = fps_pkg::IDX_W;

   logic [31:0]        drift_ff, diff_ff;
   logic signed [31:0] origin_ff, tilt_ff;
   logic [30:0]        step_ff;

   fps_pkg::state_type     state_ff, state_in;
   fps_pkg::job_type       job_ff;
   fps_pkg::force_tag_type fcnt_ff;
   logic [IW-1:0]          cnt_ff, cur_idx_ff, job_idx_ff, idx_new;
   logic                   job_end_ff, last_ff, fresh_ff, pending;
   logic signed [31:0]     s0a_ff, s1a_ff, s2a_ff, s0b_ff, s1b_ff, s2b_ff;
   logic signed [31:0]     gc_ff, g0_ff, gm_ff;
   fps_pkg::rsp_type       rsp_ff;

   logic                   accept, restart, load;
   fps_pkg::force_req_type freq;
   fps_pkg::force_rsp_type frsp;
   fps_pkg::lane_ctrl_type lctrl;
   fps_pkg::mass_ctrl_type mctrl;
   logic                   done_a, done_b, mass_done;
   logic signed [31:0]     res_a, res_b;
   logic [39:0]            l1_dist, mass_a, mass_b;

   assign accept  = req_valid && req_ready;
   assign restart = req_data.first_point || (cnt_ff == '0);
   assign pending = last_ff && !job_end_ff;

   always_comb begin
      if (restart) begin
         idx_new = fps_pkg::IDX_ONE;
      end else if (cnt_ff == fps_pkg::IDX_MAX) begin
         idx_new = fps_pkg::IDX_MAX;
      end else begin
         idx_new = cnt_ff + fps_pkg::IDX_ONE;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fps_pkg::ST_IDLE: begin
            if (accept) begin
               if (idx_new == fps_pkg::IDX_ONE) begin
                  state_in = req_data.last_point_in ? fps_pkg::ST_LOAD : fps_pkg::ST_IDLE;
               end else if (idx_new == fps_pkg::IDX_TWO && req_data.last_point_in) begin
                  state_in = fps_pkg::ST_LOAD;
               end else begin
                  state_in = fps_pkg::ST_FORCE;
               end
            end
         end
         fps_pkg::ST_FORCE: begin
            if (frsp.valid && frsp.tag == fps_pkg::FT_GM) begin
               state_in = fps_pkg::ST_LANE;
            end
         end
         fps_pkg::ST_LANE: begin
            if (done_a && done_b) begin
               state_in = fps_pkg::ST_LOAD;
            end
         end
         fps_pkg::ST_LOAD: begin
            if (!job_end_ff || mass_done) begin
               state_in = fps_pkg::ST_SEND;
            end
         end
         fps_pkg::ST_SEND: begin
            if (rsp_ready) begin
               if (!pending) begin
                  state_in = fps_pkg::ST_IDLE;
               end else if (job_ff == fps_pkg::JOB_PASS_W0) begin
                  state_in = fps_pkg::ST_LOAD;
               end else begin
                  state_in = fps_pkg::ST_LANE;
               end
            end
         end
         default: state_in = fps_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == fps_pkg::ST_IDLE);
      rsp_valid  = (state_ff == fps_pkg::ST_SEND);
      load       = (state_ff == fps_pkg::ST_LOAD) && (!job_end_ff || mass_done);
      freq.issue = (state_ff == fps_pkg::ST_FORCE) && (fcnt_ff != fps_pkg::FT_DONE);
      freq.tag   = fcnt_ff;
      case (fcnt_ff)
         fps_pkg::FT_G0: freq.idx = cur_idx_ff - fps_pkg::IDX_ONE;
         fps_pkg::FT_GM: freq.idx = cur_idx_ff - fps_pkg::IDX_TWO;
         default:        freq.idx = cur_idx_ff;
      endcase
      lctrl.start   = fresh_ff;
      lctrl.mode    = job_ff;
      mctrl.acc     = accept;
      mctrl.restart = restart;
      mctrl.finish  = req_data.last_point_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drift_ff  <= fps_pkg::DRIFT_GAIN_RST;
         diff_ff   <= fps_pkg::DIFFUSION_GAIN_RST;
         origin_ff <= fps_pkg::GRID_ORIGIN_RST;
         step_ff   <= fps_pkg::GRID_STEP_RST;
         tilt_ff   <= fps_pkg::TILT_RST;
         state_ff  <= fps_pkg::ST_IDLE;
         cnt_ff    <= '0;
         fcnt_ff   <= fps_pkg::FT_DONE;
         fresh_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               fps_pkg::CSR_DRIFT_GAIN:     drift_ff  <= csr_wdata;
               fps_pkg::CSR_DIFFUSION_GAIN: diff_ff   <= csr_wdata;
               fps_pkg::CSR_GRID_ORIGIN:    origin_ff <= csr_wdata;
               fps_pkg::CSR_GRID_STEP:      step_ff   <= csr_wdata[30:0];
               fps_pkg::CSR_TILT:           tilt_ff   <= csr_wdata;
               default:                     ;
            endcase
         end
         state_ff <= state_in;
         fresh_ff <= (state_in == fps_pkg::ST_LANE) && (state_ff != fps_pkg::ST_LANE);
         if (accept) begin
            cnt_ff  <= req_data.last_point_in ? '0 : idx_new;
            fcnt_ff <= fps_pkg::FT_GC;
         end else if (freq.issue) begin
            fcnt_ff <= fps_pkg::force_tag_type'(fcnt_ff + 2'd1);
         end
      end
      if (accept) begin
         s2a_ff     <= s1a_ff;
         s1a_ff     <= s0a_ff;
         s0a_ff     <= req_data.sample_a;
         s2b_ff     <= s1b_ff;
         s1b_ff     <= s0b_ff;
         s0b_ff     <= req_data.sample_b;
         cur_idx_ff <= idx_new;
         last_ff    <= req_data.last_point_in;
         job_end_ff <= (idx_new == fps_pkg::IDX_ONE);
         if (idx_new == fps_pkg::IDX_ONE) begin
            job_ff     <= fps_pkg::JOB_PASS_A;
            job_idx_ff <= fps_pkg::IDX_ONE;
         end else if (idx_new == fps_pkg::IDX_TWO) begin
            job_ff     <= req_data.last_point_in ? fps_pkg::JOB_PASS_W0 : fps_pkg::JOB_FIRST;
            job_idx_ff <= fps_pkg::IDX_ONE;
         end else begin
            job_ff     <= fps_pkg::JOB_INNER;
            job_idx_ff <= idx_new - fps_pkg::IDX_ONE;
         end
      end else if (rsp_valid && rsp_ready && pending) begin
         job_ff     <= (job_ff == fps_pkg::JOB_PASS_W0) ? fps_pkg::JOB_PASS_A
                                                        : fps_pkg::JOB_EDGE;
         job_idx_ff <= cur_idx_ff;
         job_end_ff <= 1'b1;
      end
      if (frsp.valid) begin
         case (frsp.tag)
            fps_pkg::FT_GC: gc_ff <= frsp.g;
            fps_pkg::FT_G0: g0_ff <= frsp.g;
            fps_pkg::FT_GM: gm_ff <= frsp.g;
            default:        ;
         endcase
      end
      if (load) begin
         case (job_ff)
            fps_pkg::JOB_PASS_W0: begin
               rsp_ff.new_a <= s1a_ff;
               rsp_ff.new_b <= s1b_ff;
            end
            fps_pkg::JOB_PASS_A: begin
               rsp_ff.new_a <= s0a_ff;
               rsp_ff.new_b <= s0b_ff;
            end
            default: begin
               rsp_ff.new_a <= res_a;
               rsp_ff.new_b <= res_b;
            end
         endcase
         rsp_ff.point_index  <= 9'(job_idx_ff);
         rsp_ff.end_of_sweep <= job_end_ff;
         rsp_ff.distance     <= job_end_ff ? l1_dist : '0;
         rsp_ff.mass_a       <= job_end_ff ? mass_a : '0;
         rsp_ff.mass_b       <= job_end_ff ? mass_b : '0;
      end
   end

   assign rsp_data = rsp_ff;

   fps_force u_force (
      .clock  (clock),
      .reset  (reset),
      .req    (freq),
      .origin (origin_ff),
      .step   (step_ff),
      .tilt   (tilt_ff),
      .rsp    (frsp)
   );

   fps_lane u_lane_a (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lctrl),
      .p_cur  (s0a_ff),
      .p_prev (s1a_ff),
      .p_old  (s2a_ff),
      .gc     (gc_ff),
      .g0     (g0_ff),
      .gm     (gm_ff),
      .drift  (drift_ff),
      .diff   (diff_ff),
      .done   (done_a),
      .result (res_a)
   );

   fps_lane u_lane_b (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lctrl),
      .p_cur  (s0b_ff),
      .p_prev (s1b_ff),
      .p_old  (s2b_ff),
      .gc     (gc_ff),
      .g0     (g0_ff),
      .gm     (gm_ff),
      .drift  (drift_ff),
      .diff   (diff_ff),
      .done   (done_b),
      .result (res_b)
   );

   fps_mass u_mass (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mctrl),
      .a       (req_data.sample_a),
      .b       (req_data.sample_b),
      .step    (step_ff),
      .l1_dist (l1_dist),
      .mass_a  (mass_a),
      .mass_b  (mass_b),
      .done    (mass_done)
   );

endmodule

>>> sv/fps_checker.sv
// Port-level assertion checker for the stencil sweep, bound to the top level.
`include "fokker_planck_stencil_sweep_macros.svh"

module fps_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fps_pkg::rsp_type rsp_data
);

   `FPS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp item changed while stalled")
   `FPS_NEVER(a_busy_excl, req_ready && rsp_valid, "input taken while an item is pending")
   `FPS_ASSERT(a_sums_zero, rsp_valid && !rsp_data.end_of_sweep |-> rsp_data.distance == 40'd0 && rsp_data.mass_a == 40'd0 && rsp_data.mass_b == 40'd0, "sums set on a non-final item")
   `FPS_NEVER(a_idx_zero, rsp_valid && rsp_data.point_index == 9'd0, "item with point index zero")

endmodule

bind fokker_planck_stencil_sweep fps_checker u_chk (.*);

>>> test/fokker_planck_stencil_sweep_chk.sv
// Checker: predicts stencil sweep results from accepted items and compares them.
`timescale 1ns / 100ps
module fokker_planck_stencil_sweep_chk (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  fps_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  fps_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output int               errors,
   output int               pending
);

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam longint unsigned SUM_LIM = (64'd1 << 42) - 1;
   localparam longint unsigned OUT_LIM = (64'd1 << 40) - 1;

   logic [31:0] drift_gain, diffusion_gain;
   logic [30:0] grid_step;
   longint      grid_origin, tilt;
   longint      win_a [2];
   longint      win_b [2];
   int          last_idx;
   longint unsigned dist_acc, mass_a_acc, mass_b_acc;
   fps_pkg::rsp_type expected_q [$];

   assign pending = expected_q.size();

   function automatic longint clamp32(longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   function automatic longint force_at(int idx);
      longint x, d, t;
      x = clamp32(grid_origin + longint'(idx) * longint'(grid_step));
      d = (x * x) >> 32;
      t = ((d - (64'sd1 << 24)) * x) >>> 28;
      return clamp32(4 * t - tilt);
   endfunction

   function automatic longint gmul(longint g, longint p);
      return (g * p) >>> 24;
   endfunction

   function automatic longint gain_mul(longint v, logic [31:0] g);
      logic signed [95:0] p;
      p = v * $signed({1'b0, g});
      return longint'(p >>> 32);
   endfunction

   function automatic longint update(longint p, longint f, longint l);
      return clamp32(p + gain_mul(f, drift_gain) + gain_mul(l, diffusion_gain));
   endfunction

   function automatic longint unsigned acc_add(longint unsigned s, longint unsigned v);
      s += v;
      return s > SUM_LIM ? SUM_LIM : s;
   endfunction

   function automatic logic [39:0] scale_sum(longint unsigned s);
      logic [127:0] r;
      r = (128'(s) * 128'(grid_step)) >> 28;
      return r > OUT_LIM ? OUT_LIM[39:0] : r[39:0];
   endfunction

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   task automatic push_point(longint a, longint b, int idx, bit fin);
      fps_pkg::rsp_type r;
      r.new_a = a[31:0];
      r.new_b = b[31:0];
      r.point_index = idx[8:0];
      r.end_of_sweep = fin;
      r.distance = fin ? scale_sum(dist_acc) : '0;
      r.mass_a = fin ? scale_sum(mass_a_acc) : '0;
      r.mass_b = fin ? scale_sum(mass_b_acc) : '0;
      expected_q.push_back(r);
   endtask

   task automatic predict_sweep(fps_pkg::req_type q);
      longint a, b, gm, g0, gc;
      int idx;
      a = longint'(q.sample_a);
      b = longint'(q.sample_b);
      if (q.first_point || last_idx == 0) begin
         idx = 1;
         dist_acc = 0;
         mass_a_acc = 0;
         mass_b_acc = 0;
      end else begin
         idx = last_idx + 1;
         if (idx > fps_pkg::MAX_POINTS - 1) idx = fps_pkg::MAX_POINTS - 1;
      end
      dist_acc = acc_add(dist_acc, abs64(a - b));
      mass_a_acc = acc_add(mass_a_acc, abs64(a));
      mass_b_acc = acc_add(mass_b_acc, abs64(b));
      if (idx == 1) begin
         if (q.last_point_in) push_point(a, b, 1, 1'b1);
      end else if (idx == 2) begin
         if (q.last_point_in) begin
            push_point(win_a[0], win_b[0], 1, 1'b0);
            push_point(a, b, 2, 1'b1);
         end else begin
            g0 = force_at(1);
            gc = force_at(2);
            push_point(update(win_a[0], gmul(gc, a) + gmul(g0, win_a[0]), a - win_a[0]),
                       update(win_b[0], gmul(gc, b) + gmul(g0, win_b[0]), b - win_b[0]),
                       1, 1'b0);
         end
      end else begin
         gm = force_at(idx - 2);
         g0 = force_at(idx - 1);
         gc = force_at(idx);
         push_point(update(win_a[0], gmul(gc, a) - gmul(gm, win_a[1]),
                           win_a[1] + a - 2 * win_a[0]),
                    update(win_b[0], gmul(gc, b) - gmul(gm, win_b[1]),
                           win_b[1] + b - 2 * win_b[0]),
                    idx - 1, 1'b0);
         if (q.last_point_in) begin
            push_point(update(a, -gmul(gc, a) - gmul(g0, win_a[0]), win_a[0] - a),
                       update(b, -gmul(gc, b) - gmul(g0, win_b[0]), win_b[0] - b),
                       idx, 1'b1);
         end
      end
      win_a[1] = win_a[0];
      win_a[0] = a;
      win_b[1] = win_b[0];
      win_b[0] = b;
      last_idx = q.last_point_in ? 0 : idx;
   endtask

   task automatic report(string field, logic [39:0] got, logic [39:0] want);
      $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
      errors++;
   endtask

   always @(posedge clock) begin
      fps_pkg::rsp_type w;
      if (reset) begin
         drift_gain = fps_pkg::DRIFT_GAIN_RST;
         diffusion_gain = fps_pkg::DIFFUSION_GAIN_RST;
         grid_origin = longint'(fps_pkg::GRID_ORIGIN_RST);
         grid_step = fps_pkg::GRID_STEP_RST;
         tilt = longint'(fps_pkg::TILT_RST);
         win_a = '{0, 0};
         win_b = '{0, 0};
         last_idx = 0;
         dist_acc = 0;
         mass_a_acc = 0;
         mass_b_acc = 0;
         errors = 0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (fps_pkg::csr_index_type'(csr_index))
               fps_pkg::CSR_DRIFT_GAIN: drift_gain = csr_wdata;
               fps_pkg::CSR_DIFFUSION_GAIN: diffusion_gain = csr_wdata;
               fps_pkg::CSR_GRID_ORIGIN: grid_origin = longint'($signed(csr_wdata));
               fps_pkg::CSR_GRID_STEP: grid_step = csr_wdata[30:0];
               fps_pkg::CSR_TILT: tilt = longint'($signed(csr_wdata));
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_sweep(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report("unexpected item", 40'(rsp_data.point_index), 40'd0);
            end else begin
               w = expected_q.pop_front();
               if (rsp_data.new_a !== w.new_a) report("new_a", 40'(rsp_data.new_a), 40'(w.new_a));
               if (rsp_data.new_b !== w.new_b) report("new_b", 40'(rsp_data.new_b), 40'(w.new_b));
               if (rsp_data.point_index !== w.point_index)
                  report("point_index", 40'(rsp_data.point_index), 40'(w.point_index));
               if (rsp_data.end_of_sweep !== w.end_of_sweep)
                  report("end_of_sweep", 40'(rsp_data.end_of_sweep), 40'(w.end_of_sweep));
               if (rsp_data.distance !== w.distance) report("distance", rsp_data.distance, w.distance);
               if (rsp_data.mass_a !== w.mass_a) report("mass_a", rsp_data.mass_a, w.mass_a);
               if (rsp_data.mass_b !== w.mass_b) report("mass_b", rsp_data.mass_b, w.mass_b);
            end
         end
      end
   end

endmodule

>>> test/fokker_planck_stencil_sweep_tb.sv
// Testbench top: drives sweeps and register settings into the stencil sweep and gives the verdict.
`timescale 1ns / 100ps
module fokker_planck_stencil_sweep_tb;

   logic             clock;
   logic             reset;
   logic             req_valid, req_ready;
   fps_pkg::req_type req_data;
   logic             rsp_valid, rsp_ready;
   fps_pkg::rsp_type rsp_data;
   logic             csr_we;
   logic [2:0]       csr_index;
   logic [31:0]      csr_wdata;
   int               errors, pending;
   int               sent;
   bit               steady;

   fokker_planck_stencil_sweep i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   fokker_planck_stencil_sweep_chk i_chk (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata,
      .errors, .pending
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int gap_len();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] sample_val();
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 3))
               0: return 32'h7fffffff;
               1: return 32'h80000000;
               2: return 32'h0;
               default: return 32'hffffffff;
            endcase
         1, 2: return $urandom;
         3: return -$urandom_range(0, 200000);
         default: return $urandom_range(0, 140000);
      endcase
   endfunction

   initial begin
      rsp_ready = 1'b0;
      forever begin
         int n;
         @(posedge clock);
         n = gap_len();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send(logic [31:0] a, logic [31:0] b, bit f, bit l);
      int n;
      req_valid <= 1'b1;
      req_data <= '{sample_a: a, sample_b: b, first_point: f, last_point_in: l};
      do @(posedge clock); while (!req_ready);
      sent++;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_regs(logic [31:0] v [5]);
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= v[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic sweep(int len, bit mark_first);
      for (int i = 0; i < len; i++)
         send(sample_val(), sample_val(), mark_first && i == 0, i == len - 1);
   endtask

   initial begin
      logic [31:0] regs [5];
      int len, r;
      sent = 0;
      steady = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short sweeps, extremes, missing and early first marks
      send(32'h7fffffff, 32'h80000000, 1, 1);
      send(32'h80000000, 32'h7fffffff, 1, 0);
      send(32'h00010000, 32'hffffffff, 0, 1);
      send(32'h00010000, 32'h00008000, 1, 0);
      send(32'h7fffffff, 32'h80000000, 0, 0);
      send(32'h80000000, 32'h7fffffff, 0, 0);
      send(32'h00000000, 32'h00010000, 0, 1);
      send(32'h00004000, 32'h00002000, 0, 0);
      send(32'h00008000, 32'h00001000, 0, 0);
      send(32'h00001000, 32'h00008000, 0, 1);
      send(32'h00010000, 32'h00010000, 1, 0);
      send(32'h00020000, 32'h00000000, 0, 0);
      send(32'h00030000, 32'h80000000, 1, 0);
      send(32'h00010000, 32'h7fffffff, 0, 0);
      send(32'hffff0000, 32'h00010000, 0, 0);
      send(32'h00000001, 32'hfffffffe, 0, 1);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: regs = '{32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'hffffffff, 32'h7fffffff};
            1: regs = '{32'h0, 32'h0, 32'h80000000, 32'h0, 32'h80000000};
            2: regs = '{fps_pkg::DRIFT_GAIN_RST, fps_pkg::DIFFUSION_GAIN_RST,
                        fps_pkg::GRID_ORIGIN_RST, 32'(fps_pkg::GRID_STEP_RST),
                        fps_pkg::TILT_RST};
            default: regs = '{$urandom, $urandom_range(0, 32'h10000000), $urandom,
                              $urandom_range(0, 32'h01000000) | ($urandom & 32'h80000000),
                              $urandom};
         endcase
         write_regs(regs);
         if (ph == 2) begin
            sweep(600, 1);
            drain();
         end
         while (sent < (ph + 1) * 80 + 16 + (ph >= 2 ? 600 : 0)) begin
            steady = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 19);
            len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 24);
            if (r < 15) begin
               sweep(len, 1);
            end else if (r < 17) begin
               sweep(len, 0);
            end else if (r < 19) begin
               sweep(len, 1);
               sweep(len, 1);
            end else begin
               for (int i = 0; i < len; i++)
                  send(sample_val(), sample_val(), $urandom_range(0, 7) == 0,
                       $urandom_range(0, 5) == 0);
            end
            if (r < 15 && len > 3) begin
               for (int i = 0; i < 3; i++) send(sample_val(), sample_val(), i == 0, 0);
            end
         end
         steady = 1'b0;
         send(sample_val(), sample_val(), 0, 1);
         drain();
      end

      if (errors == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/fps_pkg.sv
sv/fps_force.sv
sv/fps_lane.sv
sv/fps_mass.sv
sv/fokker_planck_stencil_sweep.sv
sv/fps_checker.sv
test/fokker_planck_stencil_sweep_chk.sv
test/fokker_planck_stencil_sweep_tb.sv
